/* src/pps_pkg.sv */
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

    localparam int SLOTS     = 16;
    localparam int UNIT_STEP = 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        MARK_ADD  = 2'd0,
        MARK_IDLE = 2'd1,
        MARK_SWITCH = 2'd2,
        MARK_SAME = 2'd3
    } mark_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [15:0] wait_stamp;
        logic [15:0] push_order;
        logic        started;
        logic [15:0] first_run;
    } task_t;

    // Best candidate carried along the scan chain.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] index;
        task_t             tsk;
    } cand_t;

    // Commands broadcast from the control to every slot cell.
    typedef struct packed {
        logic              write;
        logic              clear;
        logic              set_order;
        logic [SLOT_W-1:0] index;
        task_t             tsk;
        logic [15:0]       order;
    } slot_cmd_t;

    function automatic logic ranks_before(task_t a, task_t b);
        if (a.prio != b.prio) begin
            return a.prio < b.prio;
        end
        if (a.wait_stamp != b.wait_stamp) begin
            return a.wait_stamp < b.wait_stamp;
        end
        return a.push_order < b.push_order;
    endfunction

endpackage

/* src/pps_cell.sv */
// One waiting-set slot: holds a task and passes the scan candidate onward.
module pps_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pps_pkg::SLOT_W-1:0] my_index,
    input  pps_pkg::slot_cmd_t        cmd,
    input  logic                      scan_en,
    input  pps_pkg::cand_t            cand_in,
    output pps_pkg::cand_t            cand_out,
    output logic                      valid
);
    import pps_pkg::*;

    logic  valid_reg;
    task_t tsk_reg;
    cand_t cand_reg;
    cand_t cand_next;
    logic  hit;

    assign hit   = (cmd.index == my_index);
    assign valid = valid_reg;

    always_comb begin
        cand_next = cand_in;
        if (valid_reg && (!cand_in.found || ranks_before(tsk_reg, cand_in.tsk))) begin
            cand_next.found = 1'b1;
            cand_next.index = my_index;
            cand_next.tsk   = tsk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            cand_reg.found <= 1'b0;
        end else begin
            if (scan_en) begin
                cand_reg <= cand_next;
            end
            if (hit && cmd.write) begin
                valid_reg <= 1'b1;
                tsk_reg   <= cmd.tsk;
            end else if (hit && cmd.clear) begin
                valid_reg <= 1'b0;
            end else if (hit && cmd.set_order) begin
                tsk_reg.push_order <= cmd.order;
            end
        end
    end

    assign cand_out = cand_reg;

endmodule

/* src/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler: slot cell chain and control.
//
// Input requests arrive on the s_axis channel. tdata bit 0 selects the
// operation: 0 adds a task to the waiting set, 1 runs one scheduling tick.
// Each request yields exactly one result request on the m_axis channel.
// For an add, the free slot is found by a priority encoder over the slot
// valid bits. For a tick, the best candidate moves through the chain of
// slot cells, one register stage per cell, and then the running task and
// the chosen slot are updated in the same cycle.
// One request is in work at a time; s_tready is low until its result has
// been taken, so a stalled receiver holds the result and blocks new input.
// Synchronous reset empties the waiting set, clears the running task and
// sets the current time and push counter to zero.
module preemptive_priority_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[0], task_id[8:1], task_priority[16:9], burst_time[32:17],
    // arrival_stamp[48:33], zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], mark[2:1], running_valid[3], running_id[11:4],
    // completed[12], start_time[28:13], completion_time[44:29], zero fill
    output logic [47:0] m_tdata
);
    import pps_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_OUT} state_t;

    state_t         state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [55:0]    req_reg;
    logic [47:0]    out_reg;
    logic [47:0]    out_next;
    logic           run_valid_reg;
    logic [7:0]     run_id_reg;
    logic [7:0]     run_prio_reg;
    logic [15:0]    run_rem_reg;
    logic [15:0]    run_st_reg;
    logic [15:0]    now_reg;
    logic [15:0]    push_reg;

    cand_t          chain [SLOTS+1];
    logic [SLOTS-1:0] valid_vec;
    slot_cmd_t      cmd;
    logic           scan_en;
    logic           free_found;
    logic [SLOT_W-1:0] free_idx;

    assign chain[0] = '0;
    assign scan_en  = (state_reg == ST_SCAN);

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        pps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .my_index (SLOT_W'(g)),
            .cmd      (cmd),
            .scan_en  (scan_en),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1]),
            .valid    (valid_vec[g])
        );
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_vec[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Tick decisions, evaluated in ST_UPDATE from the candidate at the chain end.
    cand_t       best;
    logic        preempt;
    logic [15:0] rem_cur;
    logic [15:0] rem_new;
    logic [15:0] st_cur;
    logic [7:0]  id_cur;
    logic [7:0]  prio_cur;
    logic        run_now;

    assign best = chain[SLOTS];

    always_comb begin
        preempt  = run_valid_reg && best.found && (best.tsk.prio < run_prio_reg);
        run_now  = run_valid_reg || best.found;
        if (!run_valid_reg || preempt) begin
            id_cur   = best.tsk.id;
            prio_cur = best.tsk.prio;
            rem_cur  = best.tsk.remaining;
            st_cur   = best.tsk.started ? best.tsk.first_run : now_reg;
        end else begin
            id_cur   = run_id_reg;
            prio_cur = run_prio_reg;
            rem_cur  = run_rem_reg;
            st_cur   = run_st_reg;
        end
        rem_new = (rem_cur > 16'(UNIT_STEP)) ? rem_cur - 16'(UNIT_STEP) : 16'd0;
    end

    always_comb begin
        out_next = '0;
        if (!req_reg[0]) begin
            out_next[0] = free_found;
        end else if (!run_now) begin
            out_next[2:1] = MARK_IDLE;
        end else begin
            out_next[2:1]   = (!run_valid_reg || preempt) ? MARK_SWITCH : MARK_SAME;
            out_next[3]     = 1'b1;
            out_next[11:4]  = id_cur;
            out_next[28:13] = st_cur;
            if (rem_new == 16'd0) begin
                out_next[12]    = 1'b1;
                out_next[44:29] = now_reg + 16'(UNIT_STEP);
            end
        end
    end

    always_comb begin
        cmd = '0;
        cmd.order = push_reg;
        if (state_reg == ST_UPDATE) begin
            if (!req_reg[0]) begin
                cmd.index          = free_idx;
                cmd.write          = free_found;
                cmd.tsk.id         = req_reg[8:1];
                cmd.tsk.prio       = req_reg[16:9];
                cmd.tsk.remaining  = req_reg[32:17];
                cmd.tsk.wait_stamp = req_reg[48:33];
                cmd.tsk.push_order = push_reg;
                cmd.tsk.started    = 1'b0;
                cmd.tsk.first_run  = '0;
            end else if (best.found) begin
                cmd.index = best.index;
                if (!run_valid_reg) begin
                    cmd.clear = 1'b1;
                end else if (preempt) begin
                    cmd.write          = 1'b1;
                    cmd.tsk.id         = run_id_reg;
                    cmd.tsk.prio       = run_prio_reg;
                    cmd.tsk.remaining  = run_rem_reg;
                    cmd.tsk.wait_stamp = now_reg;
                    cmd.tsk.push_order = push_reg;
                    cmd.tsk.started    = 1'b1;
                    cmd.tsk.first_run  = run_st_reg;
                end else begin
                    cmd.set_order = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_prio_reg  <= '0;
            run_rem_reg   <= '0;
            run_st_reg    <= '0;
            now_reg       <= '0;
            push_reg      <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg   <= s_tdata;
                        cnt_reg   <= '0;
                        state_reg <= s_tdata[0] ? ST_SCAN : ST_UPDATE;
                    end
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SLOTS - 1)) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    out_reg   <= out_next;
                    state_reg <= ST_OUT;
                    if (!req_reg[0]) begin
                        if (free_found) begin
                            push_reg <= push_reg + 16'd1;
                        end
                    end else begin
                        now_reg <= now_reg + 16'(UNIT_STEP);
                        if (run_now) begin
                            if (run_valid_reg && best.found) begin
                                push_reg <= push_reg + 16'd1;
                            end
                            run_valid_reg <= (rem_new != 16'd0);
                            run_id_reg    <= id_cur;
                            run_prio_reg  <= prio_cur;
                            run_rem_reg   <= rem_new;
                            run_st_reg    <= st_cur;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

    property p_result_follows_update;
        @(posedge aclk) disable iff (!aresetn) (state_reg == ST_UPDATE) |=> m_tvalid;
    endproperty
    assert property (p_result_follows_update) else $error("result not presented");

    property p_no_accept_when_busy;
        @(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready;
    endproperty
    assert property (p_no_accept_when_busy) else $error("input taken while busy");

    property p_mark_add_clean;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[2:1] == MARK_ADD) |-> (m_tdata[47:3] == '0);
    endproperty
    assert property (p_mark_add_clean) else $error("add result carries tick fields");

    property p_done_clears_run;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_UPDATE && req_reg[0] && run_now && rem_new == 16'd0)
            |=> !run_valid_reg;
    endproperty
    assert property (p_done_clears_run) else $error("completed task still running");

endmodule

/* tb/preemptive_priority_scheduler_tb.sv */
// Self-checking testbench for the preemptive priority scheduler stream block.
module preemptive_priority_scheduler_tb;
    import pps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [15:0] finish_at;
        logic [15:0] began_at;
        logic        completed;
        logic [7:0]  running_id;
        logic        running_valid;
        mark_t       mark;
        logic        accepted;
    } sched_result_t;

    typedef struct {
        logic        op;
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] stamp;
        logic        has_known;
        sched_result_t known;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    always #6 aclk = ~aclk;

    preemptive_priority_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Scheduler state mirror.
    logic        q_valid [SLOTS];
    task_t       q_task  [SLOTS];
    logic        cur_valid;
    logic [7:0]  cur_id;
    logic [7:0]  cur_prio;
    logic [15:0] cur_left;
    logic [15:0] cur_start;
    logic [15:0] clock_now;
    logic [15:0] order_ctr;

    sched_result_t expected_results[$];
    stim_row_t rows[$];
    int errors = 0;
    int cycles = 0;
    int stall_left = 0;
    bit long_hold = 1'b0;

    function automatic bit earlier(task_t a, task_t b);
        if (a.prio != b.prio) return a.prio < b.prio;
        if (a.wait_stamp != b.wait_stamp) return a.wait_stamp < b.wait_stamp;
        return a.push_order < b.push_order;
    endfunction

    function automatic sched_result_t schedule_step(logic op, logic [7:0] id,
            logic [7:0] prio, logic [15:0] burst, logic [15:0] stamp);
        sched_result_t r;
        int pick;
        task_t old;
        r = '0;
        r.mark = MARK_ADD;
        if (op == OP_ADD) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!q_valid[i]) begin
                    q_valid[i] = 1'b1;
                    q_task[i] = '{id: id, prio: prio, remaining: burst,
                        wait_stamp: stamp, push_order: order_ctr, started: 1'b0,
                        first_run: 16'd0};
                    order_ctr++;
                    r.accepted = 1'b1;
                    break;
                end
            end
            return r;
        end
        pick = -1;
        for (int i = 0; i < SLOTS; i++)
            if (q_valid[i] && (pick < 0 || earlier(q_task[i], q_task[pick]))) pick = i;
        if (!cur_valid && pick < 0) begin
            r.mark = MARK_IDLE;
        end else begin
            if (!cur_valid || (pick >= 0 && q_task[pick].prio < cur_prio)) begin
                old = '{id: cur_id, prio: cur_prio, remaining: cur_left,
                    wait_stamp: clock_now, push_order: 16'd0, started: 1'b1,
                    first_run: cur_start};
                cur_id = q_task[pick].id;
                cur_prio = q_task[pick].prio;
                cur_left = q_task[pick].remaining;
                cur_start = q_task[pick].started ? q_task[pick].first_run : clock_now;
                q_valid[pick] = 1'b0;
                // The displaced task reuses the slot its replacement left.
                if (cur_valid) begin
                    old.push_order = order_ctr;
                    order_ctr++;
                    q_task[pick] = old;
                    q_valid[pick] = 1'b1;
                end
                cur_valid = 1'b1;
                r.mark = MARK_SWITCH;
            end else begin
                if (pick >= 0) begin
                    q_task[pick].push_order = order_ctr;
                    order_ctr++;
                end
                r.mark = MARK_SAME;
            end
            cur_left = (cur_left > 16'(UNIT_STEP)) ? 16'(cur_left - 16'(UNIT_STEP)) : 16'd0;
            r.running_valid = 1'b1;
            r.running_id = cur_id;
            r.began_at = cur_start;
            if (cur_left == 16'd0) begin
                r.completed = 1'b1;
                r.finish_at = 16'(clock_now + 16'(UNIT_STEP));
                cur_valid = 1'b0;
            end
        end
        clock_now = 16'(clock_now + 16'(UNIT_STEP));
        return r;
    endfunction

    // Offers one request after a random gap and queues the result it must produce.
    // tvalid stays high after acceptance and is dropped only when a gap follows.
    task automatic drive_request(logic op, logic [7:0] id, logic [7:0] prio,
            logic [15:0] burst, logic [15:0] stamp, logic [6:0] pad, sched_result_t want);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pad, stamp, burst, prio, id, op};
        expected_results.insert(expected_results.size(), want);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_request(logic op, logic [7:0] id, logic [7:0] prio,
            logic [15:0] burst, logic [15:0] stamp, logic [6:0] pad);
        sched_result_t want;
        want = schedule_step(op, id, prio, burst, stamp);
        drive_request(op, id, prio, burst, stamp, pad, want);
    endtask

    function automatic void add_row(logic op, logic [7:0] id, logic [7:0] prio,
            logic [15:0] burst, logic [15:0] stamp, logic has_known, sched_result_t known);
        stim_row_t row;
        row.op = op;
        row.id = id;
        row.prio = prio;
        row.burst = burst;
        row.stamp = stamp;
        row.has_known = has_known;
        row.known = known;
        rows.insert(rows.size(), row);
    endfunction

    // Receiver: random stalls, occasional longer pauses and one long hold-off.
    always @(posedge aclk) begin
        if (long_hold) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 199) == 0) begin
            stall_left = $urandom_range(10, 60);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    initial begin
        @(posedge aclk);
        wait (aresetn);
        repeat (400) @(posedge aclk);
        long_hold = 1'b1;
        repeat (300) @(posedge aclk);
        long_hold = 1'b0;
    end

    always @(posedge aclk) begin
        sched_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sched_result_t'(m_tdata[44:0]);
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[47:45] !== 3'b0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h got %h", want, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic sched_result_t add_res(logic ok);
        sched_result_t r;
        r = '0;
        r.accepted = ok;
        return r;
    endfunction

    initial begin
        sched_result_t res, idle_res;
        stim_row_t row;
        logic [7:0] n_id;
        for (int i = 0; i < SLOTS; i++) begin
            q_valid[i] = 1'b0;
            q_task[i] = '0;
        end
        cur_valid = 1'b0; cur_id = '0; cur_prio = '0; cur_left = '0; cur_start = '0;
        clock_now = '0; order_ctr = '0;
        res = '0;
        idle_res = '0;
        idle_res.mark = MARK_IDLE;

        // Directed: idle tick after reset, extreme fields, preemption, ties, full set.
        add_row(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, idle_res);
        add_row(OP_ADD, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, add_res(1'b1));
        add_row(OP_ADD, 8'hFF, 8'h00, 16'h0000, 16'h0000, 1'b1, add_res(1'b1));
        add_row(OP_TICK, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, res);
        add_row(OP_ADD, 8'h11, 8'h05, 16'd3, 16'd2, 1'b1, add_res(1'b1));
        add_row(OP_ADD, 8'h12, 8'h05, 16'd2, 16'd2, 1'b1, add_res(1'b1));
        add_row(OP_ADD, 8'h13, 8'h05, 16'd2, 16'd1, 1'b1, add_res(1'b1));
        for (int i = 0; i < 4; i++) add_row(OP_TICK, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, res);
        add_row(OP_ADD, 8'h20, 8'h01, 16'd2, 16'd9, 1'b1, add_res(1'b1));
        for (int i = 0; i < 5; i++) add_row(OP_TICK, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, res);
        for (int i = 0; i < SLOTS + 1; i++)
            add_row(OP_ADD, 8'(i), 8'hFE, 16'd1, 16'(i), 1'b0, res);
        add_row(OP_ADD, 8'h55, 8'h00, 16'd1, 16'd0, 1'b1, add_res(1'b0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) begin
            row = rows[k];
            if (row.has_known) begin
                // The mirror advances here, and the block is checked against the typed value.
                res = schedule_step(row.op, row.id, row.prio, row.burst, row.stamp);
                if (res !== row.known) begin
                    errors++;
                    $display("table row %0d: predicted %h, expected %h", k, res, row.known);
                end
                drive_request(row.op, row.id, row.prio, row.burst, row.stamp, 7'h0,
                    row.known);
            end else begin
                send_request(row.op, row.id, row.prio, row.burst, row.stamp, 7'h0);
            end
        end

        // Random: mostly short bursts and a mix of adds and ticks; rarely full.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            n_id = 8'($urandom);
            if ($urandom_range(0, 99) < 45)
                send_request(OP_ADD, n_id, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                        : 8'($urandom_range(0, 7)),
                    ($urandom_range(0, 19) == 0) ? 16'($urandom)
                        : 16'($urandom_range(0, 6)),
                    ($urandom_range(0, 2) == 0) ? 16'($urandom) : clock_now,
                    7'($urandom));
            else
                send_request(OP_TICK, n_id, 8'($urandom), 16'($urandom),
                    16'($urandom), 7'($urandom));
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
